>>> hdl/apm_pkg.sv
// Shared constants, types and decode helpers for the ADPCM sample player.
package apm_pkg;

  localparam int ROM_DEPTH   = 65536;
  localparam int ROM_AW      = $clog2(ROM_DEPTH);
  localparam int RATE_W      = 18;
  localparam int LEVEL_W     = 12;
  localparam int STEP_IDX_W  = 6;
  localparam int SAMPLE_W    = 16;

  localparam logic [RATE_W-1:0] DECODE_RATE = RATE_W'(8000);
  localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(48000);
  localparam logic [STEP_IDX_W-1:0] STEP_IDX_MAX = STEP_IDX_W'(48);

  localparam logic [2:0] FUNC_ADDR  = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_STOP  = 3'd2;
  localparam logic [2:0] FUNC_TICK  = 3'd3;
  localparam logic [2:0] FUNC_LOAD  = 3'd4;

  localparam logic [10:0] STEP_TABLE [49] = '{
    11'd16,   11'd17,   11'd19,   11'd21,   11'd23,   11'd25,   11'd28,   11'd31,
    11'd34,   11'd37,   11'd41,   11'd45,   11'd50,   11'd55,   11'd60,   11'd66,
    11'd73,   11'd80,   11'd88,   11'd97,   11'd107,  11'd118,  11'd130,  11'd143,
    11'd157,  11'd173,  11'd190,  11'd209,  11'd230,  11'd253,  11'd279,  11'd307,
    11'd337,  11'd371,  11'd408,  11'd449,  11'd494,  11'd544,  11'd598,  11'd658,
    11'd724,  11'd796,  11'd876,  11'd963,  11'd1060, 11'd1166, 11'd1282, 11'd1411,
    11'd1552
  };

  localparam logic signed [6:0] INDEX_SHIFT [8] = '{
    -7'sd1, -7'sd1, -7'sd1, -7'sd1, 7'sd2, 7'sd4, 7'sd6, 7'sd8
  };

  typedef struct packed {
    logic                        tick;
    logic                        start;
    logic                        playing;
    logic                        due;
    logic                        high;
    logic signed [SAMPLE_W-1:0]  mix_in;
  } s1_t;

  typedef struct packed {
    logic                        tick;
    logic                        playing;
    logic signed [LEVEL_W-1:0]   level;
    logic signed [SAMPLE_W-1:0]  mix_in;
  } s2_t;

  function automatic logic signed [LEVEL_W-1:0] next_level(
    input logic signed [LEVEL_W-1:0] level,
    input logic [STEP_IDX_W-1:0]     idx,
    input logic [3:0]                nib
  );
    logic [10:0]        step;
    logic [11:0]        delta;
    logic signed [13:0] sum;
    begin
      step  = STEP_TABLE[idx];
      delta = 12'(step >> 3);
      if (nib[0]) delta = delta + 12'(step >> 2);
      if (nib[1]) delta = delta + 12'(step >> 1);
      if (nib[2]) delta = delta + 12'(step);
      if (nib[3]) sum = 14'(level) - $signed({2'b00, delta});
      else        sum = 14'(level) + $signed({2'b00, delta});
      if (sum > 14'sd2047)       next_level = 12'sd2047;
      else if (sum < -14'sd2048) next_level = -12'sd2048;
      else                       next_level = sum[LEVEL_W-1:0];
    end
  endfunction

  function automatic logic [STEP_IDX_W-1:0] next_index(
    input logic [STEP_IDX_W-1:0] idx,
    input logic [3:0]            nib
  );
    logic signed [6:0] sum;
    begin
      sum = $signed({1'b0, idx}) + INDEX_SHIFT[nib[2:0]];
      if (sum < 7'sd0)                                  next_index = '0;
      else if (sum > $signed({1'b0, STEP_IDX_MAX}))     next_index = STEP_IDX_MAX;
      else                                              next_index = sum[STEP_IDX_W-1:0];
    end
  endfunction

endpackage

>>> hdl/adpcm_rom_player_mixer_top.sv
// Top level of the 4-bit ADPCM sample player and mixer.
// An accepted transaction is registered in s1_r, then s2_r, then mix_r before it is presented.
// Throughput: one transaction per cycle unless out_tready holds the output; the control
// stage, the sample store read, the decode stage and the mix stage form a stalling pipeline.
// Reset clears the play state and sets the output rate to 48000; the sample store
// is not cleared and holds whatever was loaded.
module adpcm_rom_player_mixer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [apm_pkg::RATE_W-1:0]      cfg_wr_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [39:0]                     in_tdata,   // data_byte, rom_address, mix_in
  input  logic [2:0]                      in_tuser,   // func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata   // mix_out, active, zero fill
);
  import apm_pkg::*;

  logic [RATE_W-1:0]          output_rate_r;
  logic [15:0]                pos_r, pos_nxt;
  logic                       low_next_r, low_next_nxt;
  logic                       playing_r, playing_nxt;
  logic [RATE_W-1:0]          acc_r, acc_nxt;
  logic signed [LEVEL_W-1:0]  level_r, level_nxt;
  logic [STEP_IDX_W-1:0]      idx_r, idx_nxt;
  logic [7:0]                 held_r, held_nxt;
  logic                       s1_valid_r, s2_valid_r, out_valid_r;
  s1_t                        s1_r, s1_nxt;
  s2_t                        s2_r, s2_nxt;
  logic signed [SAMPLE_W-1:0] mix_r, mix_nxt;
  logic                       active_r;

  logic [2:0]                 func;
  logic [7:0]                 data_byte;
  logic [15:0]                rom_address;
  logic signed [SAMPLE_W-1:0] mix_in;
  logic                       advance, accept;
  logic                       rom_we, rom_re;
  logic [7:0]                 rom_rdata;
  logic [RATE_W-1:0]          rate;
  logic [RATE_W:0]            sum;
  logic                       due;
  logic [3:0]                 nib;
  logic signed [LEVEL_W-1:0]  dec_level;
  logic [LEVEL_W-1:0]         mag;
  logic [16:0]                prod48;
  logic [33:0]                recip;
  logic [14:0]                quot;
  logic signed [16:0]         scaled;
  logic signed [17:0]         mixed;

  assign func        = in_tuser;
  assign data_byte   = in_tdata[7:0];
  assign rom_address = in_tdata[23:8];
  assign mix_in      = $signed(in_tdata[39:24]);

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;
  assign accept    = in_tvalid && advance;

  assign rate = (output_rate_r < DECODE_RATE) ? DECODE_RATE : output_rate_r;
  assign sum  = {1'b0, acc_r} + {1'b0, DECODE_RATE};
  assign due  = sum >= {1'b0, rate};

  assign rom_we = accept && (func == FUNC_LOAD);
  assign rom_re = accept && (func == FUNC_TICK) && playing_r && due && !low_next_r;

  apm_ram #(
    .WIDTH (8),
    .DEPTH (ROM_DEPTH)
  ) u_rom (
    .clk   (clk),
    .we    (rom_we),
    .waddr (rom_address[ROM_AW-1:0]),
    .wdata (data_byte),
    .re    (rom_re),
    .raddr (pos_r[ROM_AW-1:0]),
    .rdata (rom_rdata)
  );

  always_comb begin
    pos_nxt      = pos_r;
    low_next_nxt = low_next_r;
    playing_nxt  = playing_r;
    acc_nxt      = acc_r;
    s1_nxt.tick    = (func == FUNC_TICK);
    s1_nxt.start   = (func == FUNC_START);
    s1_nxt.due     = 1'b0;
    s1_nxt.high    = !low_next_r;
    s1_nxt.mix_in  = mix_in;
    if (accept) begin
      unique case (func)
        FUNC_ADDR: begin
          pos_nxt = {data_byte, pos_r[7:0]};
        end
        FUNC_START: begin
          playing_nxt  = 1'b1;
          low_next_nxt = 1'b0;
        end
        FUNC_STOP: begin
          playing_nxt = 1'b0;
          pos_nxt     = {pos_r[15:8], 8'h00};
        end
        FUNC_TICK: begin
          if (playing_r) begin
            if (due) begin
              acc_nxt     = RATE_W'(sum - {1'b0, rate});
              s1_nxt.due  = 1'b1;
              low_next_nxt = !low_next_r;
              if (low_next_r) begin
                pos_nxt = pos_r + 16'd1;
              end
            end else begin
              acc_nxt = sum[RATE_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
    s1_nxt.playing = playing_nxt;
  end

  always_comb begin
    nib       = s1_r.high ? rom_rdata[7:4] : held_r[3:0];
    dec_level = next_level(level_r, idx_r, nib);
    level_nxt = level_r;
    idx_nxt   = idx_r;
    held_nxt  = held_r;
    if (advance && s1_valid_r) begin
      if (s1_r.start) begin
        level_nxt = '0;
        idx_nxt   = '0;
      end else if (s1_r.tick && s1_r.playing && s1_r.due) begin
        level_nxt = dec_level;
        idx_nxt   = next_index(idx_r, nib);
        if (s1_r.high) begin
          held_nxt = rom_rdata;
        end
      end
    end
    s2_nxt.tick    = s1_r.tick;
    s2_nxt.playing = s1_r.playing;
    s2_nxt.level   = (s1_r.tick && s1_r.playing) ?
                     ((s1_r.due) ? dec_level : level_r) : '0;
    s2_nxt.mix_in  = s1_r.mix_in;
  end

  always_comb begin
    mag    = s2_r.level[LEVEL_W-1] ? LEVEL_W'(-s2_r.level) : LEVEL_W'(s2_r.level);
    prod48 = {mag, 5'b00000} + {1'b0, mag, 4'b0000};
    recip  = 34'(prod48) * 34'd52429;
    quot   = recip[32:18];
    scaled = s2_r.level[LEVEL_W-1] ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    mixed  = 18'(s2_r.mix_in) + 18'(scaled);
    if (!s2_r.tick)               mix_nxt = '0;
    else if (mixed > 18'sd32767)  mix_nxt = 16'sh7FFF;
    else if (mixed < -18'sd32768) mix_nxt = -16'sh8000;
    else                          mix_nxt = mixed[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_rate_r <= RATE_RESET;
      pos_r         <= '0;
      low_next_r    <= 1'b0;
      playing_r     <= 1'b0;
      acc_r         <= '0;
      level_r       <= '0;
      idx_r         <= '0;
      held_r        <= '0;
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        output_rate_r <= cfg_wr_data;
      end
      pos_r      <= pos_nxt;
      low_next_r <= low_next_nxt;
      playing_r  <= playing_nxt;
      acc_r      <= acc_nxt;
      level_r    <= level_nxt;
      idx_r      <= idx_nxt;
      held_r     <= held_nxt;
      if (advance) begin
        s1_valid_r  <= accept;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r     <= s1_nxt;
      s2_r     <= s2_nxt;
      mix_r    <= mix_nxt;
      active_r <= s2_r.playing;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0000000, active_r, mix_r};

endmodule

>>> hdl/apm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module apm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
